@@ design/spq_pkg.sv @@
// Shared constants and types for the sorted priority queue.
package spq_pkg;

	// Number of entry cells in the chain
	localparam int unsigned DEPTH = 16;
	// Width of the entry counter, able to hold DEPTH itself
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	// Width of the count field in a result word
	localparam int unsigned COUNT_FIELD_W = 5;
	// Width of one stored value
	localparam int unsigned VAL_W = 32;

	// Operation codes carried in the input tuser bit
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Broadcast from the top level to every cell
	typedef struct packed {
		logic                    ins;    // insert this cycle
		logic                    rem;    // remove this cycle
		logic signed [VAL_W-1:0] value;  // value to insert
	} cell_ctrl_t;

endpackage

@@ design/spq_cell.sv @@
// One slot of the sorted chain: holds a value and shifts with its neighbors.
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cell_ctrl_t               ctrl,
	input  logic                              occupied,
	input  logic                              prev_gt,
	input  logic signed [spq_pkg::VAL_W-1:0]  prev_value,
	input  logic signed [spq_pkg::VAL_W-1:0]  next_value,
	output logic                              gt,
	output logic signed [spq_pkg::VAL_W-1:0]  value
);

	logic signed [spq_pkg::VAL_W-1:0] value_q;

	// This slot stays ahead of the new value when it holds something larger
	assign gt    = occupied && (value_q > ctrl.value);
	assign value = value_q;

	// Keep, take the new value, shift down from the left, or shift up from the right
	always_ff @(posedge clk) begin
		if (ctrl.ins && !gt) begin
			value_q <= prev_gt ? ctrl.value : prev_value;
		end else if (ctrl.rem) begin
			value_q <= next_value;
		end
	end

endmodule

@@ design/sorted_priority_queue_core.sv @@
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one insert or remove per cycle while the output is not stalled; every cell compares and shifts at once.
// The output register takes a new word when it is empty or when the one it holds is taken in that cycle.
// Reset clears the entry count and the output valid flag; stored values are not cleared
// and count as empty until written.
module sorted_priority_queue_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] out_value, [32] error, [37:33] count,
	                               // [38] empty_res, [39] full_res
	output logic        m_tuser    // [0] out_valid
);

	localparam int unsigned DEPTH = spq_pkg::DEPTH;
	localparam int unsigned CNT_W = spq_pkg::CNT_W;
	localparam int unsigned CF_W  = spq_pkg::COUNT_FIELD_W;

	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 count_nxt;
	logic                             accept;
	logic                             is_full;
	logic                             is_empty;
	logic                             do_ins;
	logic                             do_rem;
	logic                             refused;
	spq_pkg::cell_ctrl_t              ctrl;
	logic [DEPTH-1:0]                 gt;
	logic signed [spq_pkg::VAL_W-1:0] vals [DEPTH];
	logic [CNT_W+CF_W-1:0]            count_ext;

	logic                             m_tvalid_q;
	logic signed [spq_pkg::VAL_W-1:0] res_value_q;
	logic                             res_valid_q;
	logic                             res_error_q;
	logic [CF_W-1:0]                  res_count_q;
	logic                             res_empty_q;
	logic                             res_full_q;

	// Accept while the output register is free or being drained
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// Decode the operation and refuse overflow and underflow
	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);
	assign do_ins   = accept && (s_tuser == spq_pkg::KIND_INSERT) && !is_full;
	assign do_rem   = accept && (s_tuser == spq_pkg::KIND_REMOVE) && !is_empty;
	assign refused  = accept && !do_ins && !do_rem;

	assign ctrl.ins   = do_ins;
	assign ctrl.rem   = do_rem;
	assign ctrl.value = s_tdata;

	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (do_rem) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	// Build the chain of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                             cell_prev_gt;
		logic signed [spq_pkg::VAL_W-1:0] cell_prev_value;
		logic signed [spq_pkg::VAL_W-1:0] cell_next_value;

		if (i == 0) begin : g_head
			assign cell_prev_gt    = 1'b1;
			assign cell_prev_value = '0;
		end else begin : g_body
			assign cell_prev_gt    = gt[i-1];
			assign cell_prev_value = vals[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign cell_next_value = '0;
		end else begin : g_inner
			assign cell_next_value = vals[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (count_q > CNT_W'(i)),
			.prev_gt    (cell_prev_gt),
			.prev_value (cell_prev_value),
			.next_value (cell_next_value),
			.gt         (gt[i]),
			.value      (vals[i])
		);
	end

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Advance the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= s_tvalid;
		end
	end

	assign count_ext = {{CF_W{1'b0}}, count_nxt};

	// Capture the result word
	always_ff @(posedge clk) begin
		if (accept) begin
			res_value_q <= do_rem ? vals[0] : '0;
			res_valid_q <= do_rem;
			res_error_q <= refused;
			res_count_q <= count_ext[CF_W-1:0];
			res_empty_q <= (count_nxt == '0);
			res_full_q  <= (count_nxt == CNT_W'(DEPTH));
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {res_full_q, res_empty_q, res_count_q, res_error_q, res_value_q};
	assign m_tuser  = res_valid_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	a_valid_no_error: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser && m_tdata[32]))
		else $error("result both valid and refused");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> m_tvalid)
		else $error("accepted word produced no result");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not advance count");
`endif

endmodule
